[hw/rtl/rcph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcph_pkg
// shared types and constants of the rc pulse hold / failsafe block
// ----------------------------------------------------------------------------
package rcph_pkg;

    localparam int CHANNELS_DEF = 6;

    localparam int CH_W    = 3;
    localparam int PULSE_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_W-1:0] PULSE_MIN_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] PULSE_MAX_RST   = 16'd2000;
    localparam logic [CFG_W-1:0] CENTER_RST      = 16'd1500;
    localparam logic [CFG_W-1:0] MAX_AGE_RST     = 16'd100;
    localparam logic [CFG_W-1:0] LINK_TIMEOUT_RST = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_MIN    = 3'd0,
        REG_PULSE_MAX    = 3'd1,
        REG_CENTER       = 3'd2,
        REG_MAX_AGE      = 3'd3,
        REG_LINK_TIMEOUT = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [CFG_W-1:0] pulse_min_us;
        logic [CFG_W-1:0] pulse_max_us;
        logic [CFG_W-1:0] center_us;
        logic [CFG_W-1:0] max_age_ms;
        logic [CFG_W-1:0] link_timeout_ms;
    } rcph_cfg_t;

    // classified slot handed from front to back
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic               fresh_ok;
        logic               fresh_bad;
        logic [PULSE_W-1:0] pulse_width;
        logic [TIME_W-1:0]  now_ms;
    } rcph_item_t;

endpackage
`default_nettype wire

[hw/rtl/rcph_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcph channel interfaces
// slot input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface rcph_slot_if import rcph_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic               new_pulse;
    logic [PULSE_W-1:0] pulse_width;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, channel, new_pulse, pulse_width, now_ms, input ready);
    modport sink   (input valid, channel, new_pulse, pulse_width, now_ms, output ready);
endinterface

interface rcph_result_if import rcph_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel_out;
    logic [PULSE_W-1:0] pulse_out;
    logic               frame_done;
    logic               frame_valid;
    logic               link_valid;

    modport source (output valid, channel_out, pulse_out, frame_done, frame_valid,
                    link_valid, input ready);
    modport sink   (input valid, channel_out, pulse_out, frame_done, frame_valid,
                    link_valid, output ready);
endinterface

interface rcph_cfg_if import rcph_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rcph_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcph_front
// accepts slots and classifies a fresh pulse against the width window
// ----------------------------------------------------------------------------
module rcph_front import rcph_pkg::*; (
    rcph_slot_if.sink  slot,
    input  rcph_cfg_t  cfg_regs,
    input  logic       push_ready,
    output logic       push_valid,
    output rcph_item_t push_item
);

    logic in_window;

    assign in_window = (slot.pulse_width >= cfg_regs.pulse_min_us) &&
                       (slot.pulse_width <= cfg_regs.pulse_max_us);

    assign slot.ready  = push_ready;
    assign push_valid  = slot.valid;

    always_comb
    begin
        push_item.channel     = slot.channel;
        push_item.fresh_ok    = slot.new_pulse & in_window;
        push_item.fresh_bad   = slot.new_pulse & ~in_window;
        push_item.pulse_width = slot.pulse_width;
        push_item.now_ms      = slot.now_ms;
    end

endmodule
`default_nettype wire

[hw/rtl/rcph_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcph_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module rcph_queue import rcph_pkg::*; #(
    parameter int W = $bits(rcph_item_t)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/rcph_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcph_back
// per-channel hold state, staleness check, frame and link tracking
// ----------------------------------------------------------------------------
module rcph_back import rcph_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  rcph_cfg_t  cfg_regs,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  rcph_item_t pop_item,
    rcph_result_if.source result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [PULSE_W-1:0] held_pulse_reg  [CHANNELS];
    logic [TIME_W-1:0]  update_time_reg [CHANNELS];
    logic               frame_ok_reg, frame_ok_next;
    logic [TIME_W-1:0]  last_valid_reg, last_valid_next;

    logic               out_valid_reg;
    logic [CH_W-1:0]    channel_out_reg;
    logic [PULSE_W-1:0] pulse_out_reg;
    logic               frame_done_reg;
    logic               frame_valid_reg;
    logic               link_valid_reg;

    logic               do_pop;
    logic [IDX_W-1:0]   idx;
    logic               ch_ok;
    logic               take_new;
    logic [PULSE_W-1:0] eff_pulse;
    logic [TIME_W-1:0]  eff_time;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  link_age;
    logic               stale;
    logic               ok;
    logic               done;
    logic               link;
    logic [PULSE_W-1:0] pulse;

    assign pop_ready = ~out_valid_reg | result.ready;
    assign do_pop    = pop_valid & pop_ready;

    assign ch_ok    = (int'(pop_item.channel) < CHANNELS);
    assign idx      = IDX_W'(pop_item.channel);
    assign take_new = ch_ok & pop_item.fresh_ok;

    // a fresh in-window pulse is held now, so it is judged with its own time
    always_comb
    begin
        eff_pulse = held_pulse_reg[idx];
        eff_time  = update_time_reg[idx];
        if (take_new)
        begin
            eff_pulse = pop_item.pulse_width;
            eff_time  = pop_item.now_ms;
        end
        age   = pop_item.now_ms - eff_time;
        stale = ~ch_ok || (eff_time == '0) ||
                (age > {{(TIME_W-CFG_W){1'b0}}, cfg_regs.max_age_ms});
        pulse = stale ? cfg_regs.center_us : eff_pulse;
        ok    = frame_ok_reg & ~(ch_ok & pop_item.fresh_bad) & ~stale;
        done  = ch_ok && (int'(pop_item.channel) == CHANNELS - 1);

        last_valid_next = last_valid_reg;
        if (done && ok)
        begin
            last_valid_next = pop_item.now_ms;
        end
        link_age = pop_item.now_ms - last_valid_next;
        link     = done && (last_valid_next != '0) &&
                   (link_age < {{(TIME_W-CFG_W){1'b0}}, cfg_regs.link_timeout_ms});
        frame_ok_next = done ? 1'b1 : ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                held_pulse_reg[i]  <= CENTER_RST;
                update_time_reg[i] <= '0;
            end
            frame_ok_reg   <= 1'b1;
            last_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                if (take_new)
                begin
                    held_pulse_reg[idx]  <= pop_item.pulse_width;
                    update_time_reg[idx] <= pop_item.now_ms;
                end
                frame_ok_reg   <= frame_ok_next;
                last_valid_reg <= last_valid_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            channel_out_reg <= pop_item.channel;
            pulse_out_reg   <= pulse;
            frame_done_reg  <= done;
            frame_valid_reg <= ok;
            link_valid_reg  <= link;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.channel_out = channel_out_reg;
    assign result.pulse_out   = pulse_out_reg;
    assign result.frame_done  = frame_done_reg;
    assign result.frame_valid = frame_valid_reg;
    assign result.link_valid  = link_valid_reg;

endmodule
`default_nettype wire

[hw/rtl/rc_pulse_hold_timeout.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc_pulse_hold_timeout
// holds rc channel pulses, substitutes the center value when stale,
// tracks frame validity and link timeout
// ----------------------------------------------------------------------------
//  port    dir   payload                                           transfer
//  slot    in    channel, new_pulse, pulse_width, now_ms           valid & ready
//  result  out   channel_out, pulse_out, frame_done, frame_valid,  valid & ready
//                link_valid
//  cfg     in    idx, data                                         valid & ready
//
// one slot per clock sustained while results are taken; a result passes through
// the two-entry queue and then the back stage result register.
// the back stage reads and updates the per-channel state in the same cycle.
// rst_n clears all state at once; no clearing pass. cfg is always ready.
// a stalled result holds the back stage, and the queue lets slots keep coming
// until it is full.
// ----------------------------------------------------------------------------
module rc_pulse_hold_timeout import rcph_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rcph_slot_if.sink     slot,
    rcph_result_if.source result,
    rcph_cfg_if.sink      cfg
);

    rcph_cfg_t  cfg_reg, cfg_next;
    logic       push_valid, push_ready;
    rcph_item_t push_item;
    logic       pop_valid, pop_ready;
    rcph_item_t pop_item;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.idx)
                REG_PULSE_MIN:    cfg_next.pulse_min_us    = cfg.data;
                REG_PULSE_MAX:    cfg_next.pulse_max_us    = cfg.data;
                REG_CENTER:       cfg_next.center_us       = cfg.data;
                REG_MAX_AGE:      cfg_next.max_age_ms      = cfg.data;
                REG_LINK_TIMEOUT: cfg_next.link_timeout_ms = cfg.data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_min_us    <= PULSE_MIN_RST;
            cfg_reg.pulse_max_us    <= PULSE_MAX_RST;
            cfg_reg.center_us       <= CENTER_RST;
            cfg_reg.max_age_ms      <= MAX_AGE_RST;
            cfg_reg.link_timeout_ms <= LINK_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rcph_front u_front (
        .slot       (slot),
        .cfg_regs   (cfg_reg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    rcph_queue #(
        .W ($bits(rcph_item_t))
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_item)
    );

    rcph_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .result    (result)
    );

endmodule
`default_nettype wire

[sim/rcph_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcph_checker
// watches the slot, result and cfg channels of rc_pulse_hold_timeout, keeps
// its own copy of the hold/failsafe state, predicts every result in order
// and compares each result transfer against the oldest prediction
// ----------------------------------------------------------------------------
module rcph_checker import rcph_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    rcph_slot_if   slot,
    rcph_result_if result,
    rcph_cfg_if    cfg,
    output int     errors,
    output int     results_seen
);

    localparam int NCH = CHANNELS_DEF;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [PULSE_W-1:0] pulse;
        logic               done;
        logic               frame_ok;
        logic               link_up;
    } slot_verdict_t;

    rcph_cfg_t          regs;
    logic [PULSE_W-1:0] held_width [NCH];
    logic [TIME_W-1:0]  stamp_ms   [NCH];
    logic               frame_good;
    logic [TIME_W-1:0]  last_good_ms;
    slot_verdict_t      pending_verdicts [$];

    // applies one slot to the held state and returns what the block must emit
    function automatic slot_verdict_t hold_and_judge(logic [CH_W-1:0] ch, logic fresh,
                                                     logic [PULSE_W-1:0] pw,
                                                     logic [TIME_W-1:0] now);
        slot_verdict_t     v;
        logic [TIME_W-1:0] age;
        v.channel  = ch;
        v.pulse    = regs.center_us;
        v.done     = 1'b0;
        v.link_up  = 1'b0;
        if (ch < NCH) begin
            if (fresh) begin
                if (pw >= regs.pulse_min_us && pw <= regs.pulse_max_us) begin
                    held_width[ch] = pw;
                    stamp_ms[ch]   = now;
                end
                else
                begin
                    frame_good = 1'b0;
                end
            end
            age = now - stamp_ms[ch];
            // a stamp of zero is treated as never held, also for a pulse held at time zero
            if (stamp_ms[ch] != '0 && age <= {16'd0, regs.max_age_ms}) begin
                v.pulse = held_width[ch];
            end
            else
            begin
                frame_good = 1'b0;
            end
            v.done = (ch == NCH - 1);
        end
        else
        begin
            frame_good = 1'b0;
        end
        v.frame_ok = frame_good;
        if (v.done) begin
            if (frame_good) begin
                last_good_ms = now;
            end
            age       = now - last_good_ms;
            v.link_up = (last_good_ms != '0) && (age < {16'd0, regs.link_timeout_ms});
            frame_good = 1'b1;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slot_verdict_t want;
        slot_verdict_t seen;
        if (!rst_n) begin
            regs.pulse_min_us    = PULSE_MIN_RST;
            regs.pulse_max_us    = PULSE_MAX_RST;
            regs.center_us       = CENTER_RST;
            regs.max_age_ms      = MAX_AGE_RST;
            regs.link_timeout_ms = LINK_TIMEOUT_RST;
            for (int i = 0; i < NCH; i++) begin
                held_width[i] = CENTER_RST;
                stamp_ms[i]   = '0;
            end
            frame_good   = 1'b1;
            last_good_ms = '0;
            pending_verdicts.delete();
            errors       <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.idx)
                    REG_PULSE_MIN:    regs.pulse_min_us    = cfg.data;
                    REG_PULSE_MAX:    regs.pulse_max_us    = cfg.data;
                    REG_CENTER:       regs.center_us       = cfg.data;
                    REG_MAX_AGE:      regs.max_age_ms      = cfg.data;
                    REG_LINK_TIMEOUT: regs.link_timeout_ms = cfg.data;
                    default: ;
                endcase
            end
            // a result never belongs to a slot taken at the same edge
            if (result.valid && result.ready) begin
                results_seen <= results_seen + 1;
                seen.channel  = result.channel_out;
                seen.pulse    = result.pulse_out;
                seen.done     = result.frame_done;
                seen.frame_ok = result.frame_valid;
                seen.link_up  = result.link_valid;
                if (pending_verdicts.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t ERROR: expected no result, actual ch=%0d pulse=%0d",
                             $time, seen.channel, seen.pulse);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (want != seen) begin
                        errors <= errors + 1;
                        $display("%0t ERROR: expected ch=%0d pulse=%0d done=%0d fvalid=%0d link=%0d",
                                 $time, want.channel, want.pulse, want.done, want.frame_ok,
                                 want.link_up);
                        $display("%0t        actual   ch=%0d pulse=%0d done=%0d fvalid=%0d link=%0d",
                                 $time, seen.channel, seen.pulse, seen.done, seen.frame_ok,
                                 seen.link_up);
                    end
                end
            end
            if (slot.valid && slot.ready)
                pending_verdicts.push_back(hold_and_judge(slot.channel, slot.new_pulse,
                                                          slot.pulse_width, slot.now_ms));
        end
    end

endmodule

[sim/tb_rc_pulse_hold_timeout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_pulse_hold_timeout
// drives rc channel slots and register settings into the pulse hold block,
// stalls both sides at random, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_rc_pulse_hold_timeout;
    import rcph_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 188;

    logic clk;
    logic rst_n;

    rcph_slot_if   slot_if();
    rcph_result_if result_if();
    rcph_cfg_if    cfg_if();

    int errors;
    int results_seen;
    int sent;
    int settings_used;
    int idle_cycles;

    logic [TIME_W-1:0] now_cur;
    logic [CFG_W-1:0]  cur_min;
    logic [CFG_W-1:0]  cur_max;
    logic [CFG_W-1:0]  cur_age;
    logic [CFG_W-1:0]  cur_timeout;

    rc_pulse_hold_timeout dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .slot   (slot_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    rcph_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot_if),
        .result       (result_if),
        .cfg          (cfg_if),
        .errors       (errors),
        .results_seen (results_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((slot_if.valid && slot_if.ready) || (result_if.valid && result_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stalls, a quiet stretch, and two long hold-offs
    initial
    begin
        int got;
        int hold_left;
        int hold_at;
        got       = 0;
        hold_left = 0;
        hold_at   = 250;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
                got++;
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (got >= hold_at) begin
                hold_left = 300;
                hold_at   = (hold_at == 250) ? 800 : 32'h7fff_ffff;
                result_if.ready <= 1'b0;
            end
            else if (got >= 500 && got < 700)
                result_if.ready <= 1'b1;
            else
                result_if.ready <= ($urandom_range(99) >= 17);
        end
    end

    task automatic send_slot(input logic [CH_W-1:0] ch, input logic fresh,
                             input logic [PULSE_W-1:0] pw, input logic [TIME_W-1:0] now);
        while ((sent < 500 || sent >= 700) && $urandom_range(99) < 17) begin
            slot_if.valid <= 1'b0;
            @(posedge clk);
        end
        slot_if.valid       <= 1'b1;
        slot_if.channel     <= ch;
        slot_if.new_pulse   <= fresh;
        slot_if.pulse_width <= pw;
        slot_if.now_ms      <= now;
        @(posedge clk);
        while (!slot_if.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic put_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.idx   <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // waits for every outstanding result, then loads a full register set
    task automatic load_settings(input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] mx,
                                 input logic [CFG_W-1:0] ctr, input logic [CFG_W-1:0] age,
                                 input logic [CFG_W-1:0] tmo);
        slot_if.valid <= 1'b0;
        while (results_seen != sent)
            @(posedge clk);
        put_reg(REG_PULSE_MIN, mn);
        put_reg(REG_PULSE_MAX, mx);
        put_reg(REG_CENTER, ctr);
        put_reg(REG_MAX_AGE, age);
        put_reg(REG_LINK_TIMEOUT, tmo);
        cfg_if.valid <= 1'b0;
        cur_min     = mn;
        cur_max     = mx;
        cur_age     = age;
        cur_timeout = tmo;
        settings_used++;
    endtask

    function automatic logic [PULSE_W-1:0] pick_width();
        if (cur_min <= cur_max && $urandom_range(99) < 90)
            return PULSE_W'($urandom_range(cur_max, cur_min));
        return PULSE_W'($urandom);
    endfunction

    // time advance per slot: mostly well inside max age, sometimes past it
    function automatic logic [TIME_W-1:0] time_step();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(cur_age / 6 + 1, 0);
        if (r < 97)
            return $urandom_range(cur_age / 2 + 1, 0);
        return $urandom_range(2 * cur_age + 3, 0);
    endfunction

    task automatic run_random(input int count);
        int target;
        int pick;
        int len;
        target = sent + count;
        while (sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8)
                now_cur = $urandom;
            else if (pick < 12)
                now_cur = now_cur + $urandom_range(cur_timeout + 50, cur_timeout / 2);
            if (pick >= 85) begin
                // broken frame: any slot number, any order, raw widths
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++) begin
                    now_cur = now_cur + time_step();
                    send_slot(CH_W'($urandom_range(7)), 1'($urandom_range(1)),
                              PULSE_W'($urandom), now_cur);
                end
            end
            else
            begin
                for (int ch = 0; ch < CHANNELS_DEF; ch++) begin
                    now_cur = now_cur + time_step();
                    send_slot(CH_W'(ch), ($urandom_range(99) < 80), pick_width(), now_cur);
                end
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        slot_if.valid <= 1'b0;
        slot_if.channel     <= '0;
        slot_if.new_pulse   <= 1'b0;
        slot_if.pulse_width <= '0;
        slot_if.now_ms      <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.idx    <= REG_PULSE_MIN;
        cfg_if.data   <= '0;
        idle_cycles   = 0;
        sent          = 0;
        settings_used = 0;
        cur_min       = PULSE_MIN_RST;
        cur_max       = PULSE_MAX_RST;
        cur_age       = MAX_AGE_RST;
        cur_timeout   = LINK_TIMEOUT_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: held at time zero stays stale, window edges, saturated width
        send_slot(3'd0, 1'b1, 16'd1500, 32'd0);
        send_slot(3'd1, 1'b1, 16'd1000, 32'd1);
        send_slot(3'd2, 1'b1, 16'd2000, 32'd1);
        send_slot(3'd3, 1'b1, 16'd999, 32'd1);
        send_slot(3'd4, 1'b1, 16'd2001, 32'd2);
        send_slot(3'd5, 1'b1, 16'hffff, 32'd2);
        // slot numbers beyond the last channel
        send_slot(3'd6, 1'b1, 16'd1500, 32'd3);
        send_slot(3'd7, 1'b0, 16'd0, 32'd3);
        // full frame just before the time counter wraps
        for (int ch = 0; ch < CHANNELS_DEF; ch++)
            send_slot(CH_W'(ch), 1'b1, PULSE_W'(1100 + 100 * ch), 32'hffff_fff0);
        // valid frame closing at time zero counts as no valid frame for the link
        for (int ch = 0; ch < CHANNELS_DEF; ch++)
            send_slot(CH_W'(ch), 1'b0, 16'd0, 32'd0);
        send_slot(3'd5, 1'b0, 16'd0, 32'd5);
        send_slot(3'd0, 1'b1, 16'd0, 32'd300);
        send_slot(3'd5, 1'b1, 16'd1500, 32'h7fff_ffff);
        now_cur = 32'd1000;

        load_settings(16'd900, 16'd2100, 16'd1500, 16'd60, 16'd300);
        run_random(PHASE_ITEMS);
        load_settings(16'd0, 16'hffff, 16'd0, 16'd0, 16'd0);
        run_random(PHASE_ITEMS);
        load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        run_random(PHASE_ITEMS);
        // empty window: no fresh pulse is ever held
        load_settings(16'd2000, 16'd1000, 16'd1234, 16'd50, 16'd200);
        run_random(PHASE_ITEMS);
        begin
            logic [CFG_W-1:0] mn;
            mn = CFG_W'($urandom_range(1500, 400));
            load_settings(mn, mn + CFG_W'($urandom_range(1200, 200)), CFG_W'($urandom),
                          CFG_W'($urandom_range(200, 10)), CFG_W'($urandom_range(1000, 20)));
        end
        run_random(PHASE_ITEMS);
        load_settings(PULSE_MIN_RST, PULSE_MAX_RST, CENTER_RST, MAX_AGE_RST, LINK_TIMEOUT_RST);
        run_random(PHASE_ITEMS);

        slot_if.valid <= 1'b0;
        while (results_seen != sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("run covered %0d slot transfers: edge cases, then random frames under %0d",
                 sent, settings_used);
        $display("register settings including empty window and all-zero / all-ones extremes");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
